### rtl/psasa_pkg.sv
`timescale 1ns / 1ps
package psasa_pkg;

    localparam int REQ_W   = 4;
    localparam int SLOT_W  = 4;
    localparam int MODE_W  = 2;
    localparam int COUNT_W = 8;

    typedef logic [REQ_W-1:0]   req_code_t;
    typedef logic [SLOT_W-1:0]  slot_num_t;
    typedef logic [MODE_W-1:0]  mode_t;
    typedef logic [COUNT_W-1:0] count_out_t;

    localparam req_code_t REQ_SESSION_START = 4'd0;
    localparam req_code_t REQ_SESSION_END   = 4'd1;
    localparam req_code_t REQ_PROMPT        = 4'd2;
    localparam req_code_t REQ_TOOL_START    = 4'd3;
    localparam req_code_t REQ_TOOL_END      = 4'd4;
    localparam req_code_t REQ_PERM_REQUEST  = 4'd5;
    localparam req_code_t REQ_PERM_DENIED   = 4'd6;
    localparam req_code_t REQ_AGENT_STOP    = 4'd7;
    localparam req_code_t REQ_UNKNOWN       = 4'd8;
    localparam req_code_t REQ_CLEAR         = 4'd9;

    localparam mode_t MODE_STOPPED = 2'd0;
    localparam mode_t MODE_IDLE    = 2'd1;
    localparam mode_t MODE_RUNNING = 2'd2;
    localparam mode_t MODE_PENDING = 2'd3;

    // Command broadcast to every cell
    typedef struct packed {
        logic      load;
        req_code_t req_type;
        slot_num_t tool_slot;
        // slot of the word in flight, held while the chain ripples
        slot_num_t pick_slot;
    } cell_cmd_t;

    // Data handed from one cell to the next
    typedef struct packed {
        mode_t      agg;
        mode_t      mode;
        count_out_t count;
    } chain_t;

endpackage

### rtl/psasa_req_if.sv
`timescale 1ns / 1ps
interface psasa_req_if
    import psasa_pkg::*;
;
    logic      valid;
    logic      ready;
    req_code_t req_type;
    slot_num_t tool_slot;

    modport source (output valid, output req_type, output tool_slot, input ready);
    modport sink   (input valid, input req_type, input tool_slot, output ready);
endinterface

### rtl/psasa_rsp_if.sv
`timescale 1ns / 1ps
interface psasa_rsp_if
    import psasa_pkg::*;
;
    logic       valid;
    logic       ready;
    mode_t      aggregate_state;
    mode_t      slot_state_out;
    count_out_t slot_count_out;

    modport source (output valid, output aggregate_state, output slot_state_out,
                    output slot_count_out, input ready);
    modport sink   (input valid, input aggregate_state, input slot_state_out,
                    input slot_count_out, output ready);
endinterface

### rtl/psasa_cell.sv
`timescale 1ns / 1ps
module psasa_cell
    import psasa_pkg::*;
#(
    parameter int IDX       = 0,
    parameter int COUNT_MAX = 255
) (
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  chain_t    chain_in,
    output chain_t    chain_out
);

    localparam int CNT_W = (COUNT_MAX < 2) ? 1 : $clog2(COUNT_MAX + 1);

    logic             valid_reg, valid_next;
    mode_t            mode_reg, mode_next;
    logic [CNT_W-1:0] count_reg, count_next;
    chain_t           chain_reg, chain_next;

    logic             hit;
    logic             pick_hit;
    logic [CNT_W-1:0] count_dec;
    mode_t            own_mode;

    assign hit       = (32'(cmd.tool_slot) == IDX);
    assign pick_hit  = (32'(cmd.pick_slot) == IDX);
    assign count_dec = (count_reg != '0) ? count_reg - CNT_W'(1) : '0;

    always_comb
    begin
        valid_next = valid_reg;
        mode_next  = mode_reg;
        count_next = count_reg;
        if (cmd.load && cmd.req_type == REQ_CLEAR)
        begin
            valid_next = 1'b0;
            mode_next  = MODE_STOPPED;
            count_next = '0;
        end
        else if (cmd.load && hit)
        begin
            // an invalid slot already sits at stopped with count zero
            valid_next = 1'b1;
            case (cmd.req_type) inside
                REQ_SESSION_START:
                begin
                    if (mode_reg == MODE_STOPPED)
                        mode_next = MODE_IDLE;
                    count_next = '0;
                end
                REQ_SESSION_END:
                begin
                    mode_next  = MODE_STOPPED;
                    count_next = '0;
                end
                REQ_PROMPT, REQ_PERM_DENIED:
                    mode_next = MODE_RUNNING;
                REQ_TOOL_START:
                begin
                    mode_next = MODE_RUNNING;
                    if (count_reg < CNT_W'(COUNT_MAX))
                        count_next = count_reg + CNT_W'(1);
                end
                REQ_TOOL_END:
                begin
                    count_next = count_dec;
                    if (count_dec == '0 && mode_reg == MODE_RUNNING)
                        mode_next = MODE_IDLE;
                end
                REQ_PERM_REQUEST:
                    mode_next = MODE_PENDING;
                REQ_AGENT_STOP:
                begin
                    mode_next  = MODE_IDLE;
                    count_next = '0;
                end
                default:
                    ;
            endcase
        end
    end

    // Fold this slot into the running maximum and pick up its word if addressed
    assign own_mode = valid_reg ? mode_reg : MODE_STOPPED;

    always_comb
    begin
        chain_next     = chain_in;
        chain_next.agg = (own_mode > chain_in.agg) ? own_mode : chain_in.agg;
        if (pick_hit)
        begin
            chain_next.mode  = mode_reg;
            chain_next.count = COUNT_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            mode_reg  <= MODE_STOPPED;
            count_reg <= '0;
            chain_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            mode_reg  <= mode_next;
            count_reg <= count_next;
            chain_reg <= chain_next;
        end
    end

    assign chain_out = chain_reg;

endmodule

### rtl/per_slot_activity_state_aggregator_core.sv
`timescale 1ns / 1ps
// Per-slot activity state aggregator.
// Channel req carries one event word (req_type, tool_slot); channel rsp returns one
// word per event: the aggregate state over valid slots, and the addressed slot's
// state and nesting count after the event. Both use valid/ready.
// The slot table is a row of NUM_SLOTS cells. An accepted event updates the
// addressed cell (or all cells on clear) at the accepting edge. The aggregate and
// the addressed slot's word then ripple through the cell row, one cell per cycle.
// One event is in flight at a time: req is freed only once the result leaves the
// cell row for the output register. The next event is taken while the previous
// result still sits in the output register.
// Reset clears every slot to invalid, stopped, count zero, and drops any result.
// If rsp stalls, the finished result waits in the output register and a following
// event holds in the cell row until that register is taken.
module per_slot_activity_state_aggregator_core
    import psasa_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int COUNT_MAX = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    psasa_req_if.sink   req,
    psasa_rsp_if.source rsp
);

    localparam int WAIT_W = $clog2(NUM_SLOTS + 1);

    cell_cmd_t cmd;
    chain_t    chain [NUM_SLOTS+1];

    logic              busy_reg, busy_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic              out_valid_reg, out_valid_next;
    slot_num_t         pick_reg, pick_next;
    chain_t            out_reg;
    logic              accept;
    logic              load_out;

    assign accept        = req.valid && req.ready;
    assign req.ready     = !busy_reg;
    assign cmd.load      = accept;
    assign cmd.req_type  = req.req_type;
    assign cmd.tool_slot = req.tool_slot;
    assign cmd.pick_slot = pick_reg;
    assign chain[0]      = '0;

    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_cell
        psasa_cell #(
            .IDX       (i),
            .COUNT_MAX (COUNT_MAX)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

    assign load_out = busy_reg && wait_reg == '0 && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        busy_next      = busy_reg;
        wait_next      = wait_reg;
        out_valid_next = out_valid_reg;
        pick_next      = pick_reg;
        if (rsp.ready)
            out_valid_next = 1'b0;
        if (accept)
        begin
            busy_next = 1'b1;
            wait_next = WAIT_W'(NUM_SLOTS);
            pick_next = req.tool_slot;
        end
        else if (busy_reg && wait_reg != '0)
            wait_next = wait_reg - WAIT_W'(1);
        if (load_out)
        begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
            pick_reg      <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
            pick_reg      <= pick_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            out_reg <= chain[NUM_SLOTS];
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.aggregate_state = out_reg.agg;
    assign rsp.slot_state_out  = out_reg.mode;
    assign rsp.slot_count_out  = out_reg.count;

    a_accept_starts_wait: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && wait_reg == WAIT_W'(NUM_SLOTS))
        else $error("accepted word did not start the cell row wait");

    a_idle_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> wait_reg == '0)
        else $error("wait counter running while idle");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(busy_reg) && !busy_reg)
        else $error("result appeared without a word in flight");

    a_agg_covers_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.aggregate_state >= rsp.slot_state_out)
        else $error("aggregate below the addressed slot's state");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import psasa_pkg::*;

    localparam int TABLE_SLOTS    = 16;
    localparam int NEST_MAX       = 255;
    localparam int RESULT_LATENCY = TABLE_SLOTS + 1;
    localparam int RANDOM_WORDS   = 800;
    localparam int CYCLE_LIMIT    = 400000;

    typedef struct {
        req_code_t req_type;
        slot_num_t tool_slot;
        int        hold;   // idle cycles before the word is offered
        bit        drain;  // offer only once every status word is back
    } event_word_t;

    typedef struct {
        mode_t      agg;
        mode_t      mode;
        count_out_t count;
    } status_word_t;

    logic clk;
    logic rst_n;

    psasa_req_if ev_ch ();
    psasa_rsp_if st_ch ();

    per_slot_activity_state_aggregator_core #(
        .NUM_SLOTS(TABLE_SLOTS),
        .COUNT_MAX(NEST_MAX)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (ev_ch),
        .rsp  (st_ch)
    );

    // Shadow of the slot table
    bit    slot_live  [TABLE_SLOTS];
    mode_t slot_mode  [TABLE_SLOTS];
    int    slot_depth [TABLE_SLOTS];

    event_word_t  pending_words[$];
    status_word_t expected_status[$];
    event_word_t  in_flight;

    bit idle_on;
    int words_queued;
    int wait_cycles;
    int stall_left;
    int cycle_count;
    int error_count;
    int words_sent;
    int words_checked;
    int depth_peak;
    int clears_sent;

    function automatic void empty_table();
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            slot_live[i]  = 1'b0;
            slot_mode[i]  = MODE_STOPPED;
            slot_depth[i] = 0;
        end
    endfunction

    function automatic mode_t table_peak();
        mode_t best;
        best = MODE_STOPPED;
        for (int i = 0; i < TABLE_SLOTS; i++)
            if (slot_live[i] && slot_mode[i] > best)
                best = slot_mode[i];
        return best;
    endfunction

    // Apply one event to the shadow table and return the status word it yields
    function automatic status_word_t advance_table(event_word_t w);
        status_word_t r;
        mode_t        m;
        int           c;
        int           s;
        s = int'(w.tool_slot);
        if (w.req_type == REQ_CLEAR)
        begin
            empty_table();
            clears_sent++;
            r.agg   = MODE_STOPPED;
            r.mode  = MODE_STOPPED;
            r.count = '0;
            return r;
        end
        if (s >= TABLE_SLOTS)
        begin
            r.agg   = table_peak();
            r.mode  = MODE_STOPPED;
            r.count = '0;
            return r;
        end
        if (!slot_live[s])
        begin
            slot_live[s]  = 1'b1;
            slot_mode[s]  = MODE_STOPPED;
            slot_depth[s] = 0;
        end
        m = slot_mode[s];
        c = slot_depth[s];
        case (w.req_type)
            REQ_SESSION_START:
            begin
                if (m == MODE_STOPPED)
                    m = MODE_IDLE;
                c = 0;
            end
            REQ_SESSION_END:
            begin
                m = MODE_STOPPED;
                c = 0;
            end
            REQ_PROMPT, REQ_PERM_DENIED:
                m = MODE_RUNNING;
            REQ_TOOL_START:
            begin
                m = MODE_RUNNING;
                if (c < NEST_MAX)
                    c++;
            end
            REQ_TOOL_END:
            begin
                if (c > 0)
                    c--;
                if (c == 0 && m == MODE_RUNNING)
                    m = MODE_IDLE;
            end
            REQ_PERM_REQUEST:
                m = MODE_PENDING;
            REQ_AGENT_STOP:
            begin
                m = MODE_IDLE;
                c = 0;
            end
            default:
                ;
        endcase
        slot_mode[s]  = m;
        slot_depth[s] = c;
        if (c > depth_peak)
            depth_peak = c;
        r.agg   = table_peak();
        r.mode  = m;
        r.count = count_out_t'(c);
        return r;
    endfunction

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_word(input req_code_t rq, input slot_num_t sl, input bit drain = 1'b0);
        event_word_t w;
        w.req_type  = rq;
        w.tool_slot = sl;
        w.hold      = idle_on ? pick_gap() : 0;
        w.drain     = drain;
        pending_words.push_back(w);
        words_queued++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Event driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_ch.valid     <= 1'b0;
            ev_ch.req_type  <= REQ_UNKNOWN;
            ev_ch.tool_slot <= '0;
            wait_cycles = 0;
        end
        else
        begin
            if (ev_ch.valid && ev_ch.ready)
            begin
                expected_status.push_back(advance_table(in_flight));
                words_sent++;
            end
            if (!ev_ch.valid || ev_ch.ready)
            begin
                if (pending_words.size() != 0 && wait_cycles < pending_words[0].hold)
                begin
                    wait_cycles++;
                    ev_ch.valid <= 1'b0;
                end
                else if (pending_words.size() != 0 &&
                         !(pending_words[0].drain && expected_status.size() != 0))
                begin
                    in_flight = pending_words.pop_front();
                    wait_cycles = 0;
                    ev_ch.valid     <= 1'b1;
                    ev_ch.req_type  <= in_flight.req_type;
                    ev_ch.tool_slot <= in_flight.tool_slot;
                end
                else
                    ev_ch.valid <= 1'b0;
            end
        end
    end

    // Status monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        status_word_t want;
        if (!rst_n)
        begin
            st_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (st_ch.valid && st_ch.ready)
            begin
                if (expected_status.size() == 0)
                begin
                    $error("status word with no event outstanding: agg %0d state %0d count %0d",
                           st_ch.aggregate_state, st_ch.slot_state_out, st_ch.slot_count_out);
                    error_count++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    words_checked++;
                    if (st_ch.aggregate_state !== want.agg)
                    begin
                        $error("aggregate_state: expected %0d, got %0d",
                               want.agg, st_ch.aggregate_state);
                        error_count++;
                    end
                    if (st_ch.slot_state_out !== want.mode)
                    begin
                        $error("slot_state_out: expected %0d, got %0d",
                               want.mode, st_ch.slot_state_out);
                        error_count++;
                    end
                    if (st_ch.slot_count_out !== want.count)
                    begin
                        $error("slot_count_out: expected %0d, got %0d",
                               want.count, st_ch.slot_count_out);
                        error_count++;
                    end
                end
            end
            // Stall only in two of every three stretches
            if (stall_left > 0)
            begin
                stall_left--;
                st_ch.ready <= 1'b0;
            end
            else
            begin
                st_ch.ready <= 1'b1;
                if ((cycle_count / 3000) % 3 != 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        slot_num_t sl;
        int        pick;
        int        depth;
        bit        burst_done;
        rst_n <= 1'b0;
        empty_table();
        idle_on = 1'b0;
        burst_done = 1'b0;

        // Directed: fresh slot, repeated session start, nesting and its floor
        add_word(REQ_UNKNOWN, 4'd0);
        add_word(REQ_SESSION_START, 4'd0);
        add_word(REQ_SESSION_START, 4'd0);
        add_word(REQ_PROMPT, 4'd15);
        add_word(REQ_TOOL_START, 4'd15);
        add_word(REQ_TOOL_START, 4'd15);
        add_word(REQ_TOOL_END, 4'd15);
        add_word(REQ_TOOL_END, 4'd15);
        add_word(REQ_TOOL_END, 4'd15);
        // Pending on a fresh slot, kept by a session start
        add_word(REQ_PERM_REQUEST, 4'd5);
        add_word(REQ_SESSION_START, 4'd5);
        add_word(REQ_PERM_DENIED, 4'd5);
        add_word(REQ_AGENT_STOP, 4'd5);
        add_word(REQ_SESSION_END, 4'd0);
        add_word(REQ_SESSION_START, 4'd10);
        add_word(REQ_TOOL_END, 4'd10);
        // Undefined codes act as unknown
        for (int k = int'(REQ_CLEAR) + 1; k < (1 << REQ_W); k++)
            add_word(req_code_t'(k), slot_num_t'(k));
        add_word(REQ_CLEAR, 4'd7);
        add_word(REQ_PROMPT, 4'd3);

        // Random: mostly well-formed sessions, some noise, rare clears
        words_queued = 0;
        while (words_queued < RANDOM_WORDS)
        begin
            idle_on = (words_queued / 150) % 3 != 0;
            pick = $urandom_range(0, 99);
            sl = slot_num_t'($urandom_range(0, TABLE_SLOTS - 1));
            if (!burst_done && words_queued > 300)
            begin
                // Drive one slot past the nesting limit
                burst_done = 1'b1;
                add_word(REQ_SESSION_START, sl, 1'b1);
                repeat (NEST_MAX + 3)
                    add_word(REQ_TOOL_START, sl);
                repeat (3)
                    add_word(REQ_TOOL_END, sl);
                add_word(REQ_AGENT_STOP, sl);
            end
            else if (pick < 70)
            begin
                depth = $urandom_range(0, 4);
                add_word(REQ_SESSION_START, sl, words_queued % 100 < 4);
                add_word(REQ_PROMPT, sl);
                repeat (depth)
                    add_word(REQ_TOOL_START, sl);
                if ($urandom_range(0, 2) == 0)
                begin
                    add_word(REQ_PERM_REQUEST, sl);
                    add_word($urandom_range(0, 1) ? REQ_PERM_DENIED : REQ_PROMPT, sl);
                end
                repeat (depth + $urandom_range(0, 1))
                    add_word(REQ_TOOL_END, sl);
                if ($urandom_range(0, 1))
                    add_word(REQ_AGENT_STOP, sl);
                if ($urandom_range(0, 1))
                    add_word(REQ_SESSION_END, sl);
            end
            else if (pick < 97)
                add_word(req_code_t'($urandom_range(0, (1 << REQ_W) - 1)), sl);
            else
                add_word(REQ_CLEAR, sl);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || ev_ch.valid || expected_status.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY + 8) @(posedge clk);

        $display("covered %0d event words and %0d status words, %0d clears",
                 words_sent, words_checked, clears_sent);
        $display("deepest tool nesting reached %0d (limit %0d)", depth_peak, NEST_MAX);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
